### hw/rtl/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg: shared types and constants for the ray/box slab test
// Q16.16 limits, divider pipeline shape, configuration register indexes and
// the interval record passed between the per-axis stages.
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int AXES            = 3;
    localparam int QW              = 32;
    localparam int DIV_BITS        = 32;
    localparam int DIV_BITS_STAGE  = 2;
    localparam int DIV_STAGES      = DIV_BITS / DIV_BITS_STAGE;
    // Pre stage, iteration stages and the saturation stage.
    localparam int DIV_LATENCY     = DIV_STAGES + 2;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                   hit;
        logic signed [QW-1:0]   near_q;
        logic signed [QW-1:0]   far_q;
    } ival_t;

endpackage

### hw/rtl/ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test: streaming ray versus axis-aligned box test
// The ray sits in six configuration registers (origin x/y/z, direction x/y/z,
// indexes 0 to 5, signed Q16.16). Each input word carries one box and an
// incoming interval; each result word gives the hit flag and the narrowed
// interval.
//
// Usage: write the ray through cfg_wen/cfg_idx/cfg_wdata while no word is in
// flight, then stream boxes on s_t*. A word is taken whenever s_tvalid and
// s_tready are high; one box is accepted per cycle while the receiver does not stall.
// Each word passes through the six parallel distance dividers (two quotient
// bits per stage) and then one registered stage per axis. Throughput is one
// word per cycle while the receiver does not stall.
// When the receiver stalls, the whole pipeline holds and s_tready drops; a
// new word is still taken in the cycle the waiting result leaves.
// Reset clears the ray registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module ray_box_slab_test (
    input  logic        aclk,
    input  logic        aresetn,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // near_in, far_in
    input  logic [255:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hit, near_out, far_out, zero pad
    output logic [71:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_wen,
    input  logic [rbst_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [rbst_pkg::QW-1:0]        cfg_wdata
);
    import rbst_pkg::*;

    localparam int LAT = DIV_LATENCY + AXES;

    logic signed [QW-1:0] org_reg [AXES];
    logic signed [QW-1:0] dir_reg [AXES];

    logic                 adv;
    logic                 vld_reg [LAT];
    logic signed [QW-1:0] near_reg [DIV_LATENCY];
    logic signed [QW-1:0] far_reg  [DIV_LATENCY];

    logic signed [QW-1:0] dmin [AXES];
    logic signed [QW-1:0] dmax [AXES];
    logic signed [QW-1:0] dy0_reg, dy1_reg;
    logic signed [QW-1:0] dz0_reg [2];
    logic signed [QW-1:0] dz1_reg [2];

    ival_t ival_start, ival_x, ival_y, ival_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                org_reg[a] <= '0;
                dir_reg[a] <= '0;
            end
        end else if (cfg_wen) begin
            case (cfg_idx)
                CFG_ORIGIN_X: org_reg[0] <= cfg_wdata;
                CFG_ORIGIN_Y: org_reg[1] <= cfg_wdata;
                CFG_ORIGIN_Z: org_reg[2] <= cfg_wdata;
                CFG_DIR_X:    dir_reg[0] <= cfg_wdata;
                CFG_DIR_Y:    dir_reg[1] <= cfg_wdata;
                CFG_DIR_Z:    dir_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            near_reg[0] <= s_tdata[223:192];
            far_reg[0]  <= s_tdata[255:224];
            for (int i = 1; i < DIV_LATENCY; i++) begin
                near_reg[i] <= near_reg[i-1];
                far_reg[i]  <= far_reg[i-1];
            end
            dy0_reg    <= dmin[1];
            dy1_reg    <= dmax[1];
            dz0_reg[0] <= dmin[2];
            dz1_reg[0] <= dmax[2];
            dz0_reg[1] <= dz0_reg[0];
            dz1_reg[1] <= dz1_reg[0];
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        rbst_div u_div_min (
            .aclk   (aclk),
            .en     (adv),
            .plane  (s_tdata[a*QW +: QW]),
            .org    (org_reg[a]),
            .dir    (dir_reg[a]),
            .dist_q (dmin[a])
        );
        rbst_div u_div_max (
            .aclk   (aclk),
            .en     (adv),
            .plane  (s_tdata[(a+AXES)*QW +: QW]),
            .org    (org_reg[a]),
            .dir    (dir_reg[a]),
            .dist_q (dmax[a])
        );
    end

    assign ival_start = '{hit: 1'b1, near_q: near_reg[DIV_LATENCY-1],
                          far_q: far_reg[DIV_LATENCY-1]};

    rbst_slab u_slab_x (
        .aclk     (aclk),
        .en       (adv),
        .ival_in  (ival_start),
        .d0       (dmin[0]),
        .d1       (dmax[0]),
        .ival_out (ival_x)
    );

    rbst_slab u_slab_y (
        .aclk     (aclk),
        .en       (adv),
        .ival_in  (ival_x),
        .d0       (dy0_reg),
        .d1       (dy1_reg),
        .ival_out (ival_y)
    );

    rbst_slab u_slab_z (
        .aclk     (aclk),
        .en       (adv),
        .ival_in  (ival_y),
        .d0       (dz0_reg[1]),
        .d1       (dz1_reg[1]),
        .ival_out (ival_z)
    );

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {7'd0, ival_z.far_q, ival_z.near_q, ival_z.hit};

`ifndef SYNTHESIS
    a_hit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ival_z.hit |-> ival_z.far_q > ival_z.near_q)
        else $error("hit reported with an empty interval");

    a_miss_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !ival_z.hit |-> ival_z.far_q <= ival_z.near_q)
        else $error("miss reported with a nonempty interval");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg[0]) && $stable(vld_reg[LAT-1]) && $stable(ival_z))
        else $error("pipeline moved during a stall");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");
`endif

endmodule

### hw/rtl/rbst_div.sv
// ----------------------------------------------------------------------------
// rbst_div: pipelined saturating plane distance divider
// Computes ((plane - origin) << 16) / dir in Q16.16, truncated toward zero and
// saturated, two quotient bits per stage.
// ----------------------------------------------------------------------------
module rbst_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [rbst_pkg::QW-1:0] plane,
    input  logic signed [rbst_pkg::QW-1:0] org,
    input  logic signed [rbst_pkg::QW-1:0] dir,
    output logic signed [rbst_pkg::QW-1:0] dist_q
);
    import rbst_pkg::*;

    logic [QW-1:0]  magd;

    logic [QW-1:0]  r_reg [DIV_STAGES+1];
    logic [QW-1:0]  n_reg [DIV_STAGES+1];
    logic [QW-1:0]  q_reg [DIV_STAGES+1];
    logic           ovf_reg  [DIV_STAGES+1];
    logic           neg_reg  [DIV_STAGES+1];
    logic           zero_reg [DIV_STAGES+1];
    logic           dneg_reg [DIV_STAGES+1];

    logic signed [QW:0] diff;
    logic [QW:0]        magn;
    logic [QW-1:0]      q_fin;
    logic signed [QW-1:0] dist_next;
    logic signed [QW-1:0] dist_reg;

    // The user must change the direction only while the pipeline is empty; the block itself does not enforce this.
    assign magd = dir[QW-1] ? QW'(-dir) : QW'(dir);

    always_comb begin
        diff = {plane[QW-1], plane} - {org[QW-1], org};
        magn = diff[QW] ? (QW+1)'(-diff) : (QW+1)'(diff);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]    <= QW'(magn[QW:16]);
            n_reg[0]    <= {magn[15:0], 16'd0};
            q_reg[0]    <= '0;
            ovf_reg[0]  <= {15'd0, magn} >= {magd, 16'd0};
            neg_reg[0]  <= diff[QW] ^ dir[QW-1];
            zero_reg[0] <= (dir == '0);
            dneg_reg[0] <= diff[QW];
        end
    end

    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
        logic [QW-1:0] r_next, n_next, q_next;
        logic [QW:0]   t;

        always_comb begin
            r_next = r_reg[s-1];
            n_next = n_reg[s-1];
            q_next = q_reg[s-1];
            t      = '0;
            for (int k = 0; k < DIV_BITS_STAGE; k++) begin
                t      = {r_next, n_next[QW-1]};
                n_next = {n_next[QW-2:0], 1'b0};
                if (t >= {1'b0, magd}) begin
                    r_next = QW'(t - {1'b0, magd});
                    q_next = {q_next[QW-2:0], 1'b1};
                end else begin
                    r_next = t[QW-1:0];
                    q_next = {q_next[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[s]    <= r_next;
                n_reg[s]    <= n_next;
                q_reg[s]    <= q_next;
                ovf_reg[s]  <= ovf_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                dneg_reg[s] <= dneg_reg[s-1];
            end
        end
    end

    always_comb begin
        q_fin = q_reg[DIV_STAGES];
        if (zero_reg[DIV_STAGES]) begin
            dist_next = dneg_reg[DIV_STAGES] ? Q_MIN : Q_MAX;
        end else if (ovf_reg[DIV_STAGES]) begin
            dist_next = neg_reg[DIV_STAGES] ? Q_MIN : Q_MAX;
        end else if (neg_reg[DIV_STAGES]) begin
            dist_next = (q_fin > 32'h8000_0000) ? Q_MIN : QW'(-q_fin);
        end else begin
            dist_next = q_fin[QW-1] ? Q_MAX : q_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
        end
    end

    assign dist_q = dist_reg;

endmodule

### hw/rtl/rbst_slab.sv
// ----------------------------------------------------------------------------
// rbst_slab: one axis of the slab test
// Orders the two plane distances, narrows the interval and flags a miss.
// An interval that has already missed passes through unchanged.
// ----------------------------------------------------------------------------
module rbst_slab (
    input  logic                           aclk,
    input  logic                           en,
    input  rbst_pkg::ival_t                ival_in,
    input  logic signed [rbst_pkg::QW-1:0] d0,
    input  logic signed [rbst_pkg::QW-1:0] d1,
    output rbst_pkg::ival_t                ival_out
);
    import rbst_pkg::*;

    logic signed [QW-1:0] t0, t1;
    ival_t ival_next;
    ival_t ival_reg;

    always_comb begin
        t0 = (d0 < d1) ? d0 : d1;
        t1 = (d0 < d1) ? d1 : d0;
        ival_next = ival_in;
        if (ival_in.hit) begin
            ival_next.near_q = (t0 > ival_in.near_q) ? t0 : ival_in.near_q;
            ival_next.far_q  = (t1 < ival_in.far_q) ? t1 : ival_in.far_q;
            ival_next.hit    = ival_next.far_q > ival_next.near_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ival_reg <= ival_next;
        end
    end

    assign ival_out = ival_reg;

endmodule

### verif/tb_ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// tb_ray_box_slab_test: self-checking bench for the ray/box slab test
// Streams directed and random boxes under several ray settings, predicts each
// result word with a behavioral slab model and compares hit, near and far in
// order. Both sides idle at random, and the receiver once stalls for a long
// stretch so that the pipeline fills and holds off the sender.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rbst_pkg::*;

    typedef struct packed {
        logic signed [31:0] far_q;
        logic signed [31:0] near_q;
        logic signed [31:0] hi_z, hi_y, hi_x;
        logic signed [31:0] lo_z, lo_y, lo_x;
    } box_word_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] near_q;
        logic signed [31:0] far_q;
    } slab_result_t;

    class slab_scoreboard;
        logic signed [31:0] origin [3];
        logic signed [31:0] dirv [3];
        slab_result_t pending [$];
        int errors;
        int reported;

        function new();
            errors = 0;
            reported = 0;
            foreach (origin[a]) begin
                origin[a] = 0;
                dirv[a] = 0;
            end
        endfunction

        function logic signed [31:0] plane_dist(logic signed [31:0] plane, int a);
            logic signed [63:0] diff;
            logic signed [63:0] q;
            diff = 64'(plane) - 64'(origin[a]);
            if (dirv[a] == 0)
                return (diff >= 0) ? Q_MAX : Q_MIN;
            q = (diff * 64'sd65536) / 64'(dirv[a]);
            if (q > 64'(Q_MAX)) q = 64'(Q_MAX);
            if (q < 64'(Q_MIN)) q = 64'(Q_MIN);
            return q[31:0];
        endfunction

        function void note_box(box_word_t w);
            slab_result_t r;
            logic signed [31:0] lo [3];
            logic signed [31:0] hi [3];
            logic signed [31:0] d0, d1, t0, t1;
            lo = '{w.lo_x, w.lo_y, w.lo_z};
            hi = '{w.hi_x, w.hi_y, w.hi_z};
            r.hit = 1'b1;
            r.near_q = w.near_q;
            r.far_q = w.far_q;
            for (int a = 0; a < 3; a++) begin
                d0 = plane_dist(lo[a], a);
                d1 = plane_dist(hi[a], a);
                t0 = (d0 < d1) ? d0 : d1;
                t1 = (d0 < d1) ? d1 : d0;
                if (t0 > r.near_q) r.near_q = t0;
                if (t1 < r.far_q) r.far_q = t1;
                if (r.far_q <= r.near_q) begin
                    r.hit = 1'b0;
                    break;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [71:0] d);
            slab_result_t e;
            if (pending.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected result word %h", d);
                end
                return;
            end
            e = pending.pop_front();
            if (d[0] !== e.hit || d[32:1] !== e.near_q || d[64:33] !== e.far_q) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("mismatch: expected hit %0d near %h far %h, got hit %0d near %h far %h",
                             e.hit, e.near_q, e.far_q, d[0], d[32:1], d[64:33]);
                end
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [255:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [31:0]  cfg_wdata = '0;

    slab_scoreboard sb = new();
    bit long_stall_req = 1'b0;

    ray_box_slab_test dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Random value weighted toward the edges and small magnitudes.
    function automatic logic [31:0] pick_q();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sb.origin[0] = (idx == CFG_ORIGIN_X) ? val : sb.origin[0];
        sb.origin[1] = (idx == CFG_ORIGIN_Y) ? val : sb.origin[1];
        sb.origin[2] = (idx == CFG_ORIGIN_Z) ? val : sb.origin[2];
        sb.dirv[0] = (idx == CFG_DIR_X) ? val : sb.dirv[0];
        sb.dirv[1] = (idx == CFG_DIR_Y) ? val : sb.dirv[1];
        sb.dirv[2] = (idx == CFG_DIR_Z) ? val : sb.dirv[2];
    endtask

    // The valid line stays high between back-to-back words and drops only
    // for an idle gap or when the stream pauses in drain.
    task automatic send_box(box_word_t w);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (long_stall_req) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= w;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_box(w);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (30) @(posedge aclk);
    endtask

    function automatic box_word_t rand_box();
        box_word_t w;
        logic signed [31:0] lo, sz;
        w.near_q = ($urandom_range(0, 3) == 0) ? pick_q() : 32'sh0;
        w.far_q = ($urandom_range(0, 3) == 0) ? pick_q() : 32'sh7FFF_FFFF;
        if ($urandom_range(0, 4) == 0) begin
            w.lo_x = pick_q(); w.lo_y = pick_q(); w.lo_z = pick_q();
            w.hi_x = pick_q(); w.hi_y = pick_q(); w.hi_z = pick_q();
        end else begin
            // Well-formed box near the ray so that many reach all three axes.
            lo = pick_q(); sz = $urandom_range(1, 32'h0008_0000);
            w.lo_x = lo; w.hi_x = lo + sz;
            lo = pick_q(); sz = $urandom_range(1, 32'h0008_0000);
            w.lo_y = lo; w.hi_y = lo + sz;
            lo = pick_q(); sz = $urandom_range(1, 32'h0008_0000);
            w.lo_z = lo; w.hi_z = lo + sz;
        end
        return w;
    endfunction

    task automatic set_ray(int mode);
        cfg_idx_t idx;
        for (int i = 0; i < 6; i++) begin
            idx = cfg_idx_t'(i);
            case (mode)
                0: write_reg(idx, (i < 3) ? 32'h0 : 32'h0001_0000);
                1: write_reg(idx, (i < 3) ? 32'h7FFF_FFFF : 32'h8000_0000);
                2: write_reg(idx, (i < 3) ? 32'h8000_0000 : 32'h7FFF_FFFF);
                3: write_reg(idx, (i == 4) ? 32'h0 : ((i < 3) ? pick_q() : 32'h0000_0001));
                4: write_reg(idx, (i < 3) ? 32'hFFFF_FFFF : 32'h0);
                default: write_reg(idx, pick_q());
            endcase
        end
    endtask

    // Receiver with random stalls plus one long hold-off on request.
    initial begin : receiver
        int stall;
        forever begin
            @(posedge aclk);
            if (long_stall_req) begin
                m_tready <= 1'b0;
                repeat (200) @(posedge aclk);
                long_stall_req = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
            m_tready <= 1'b0;
        end
    end

    initial begin : stimulus
        box_word_t w;
        logic [31:0] ext [6];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset ray: zero origin and direction, so division-by-zero cases, zero over zero among them.
        w = '{far_q: 32'sh7FFF_FFFF, near_q: 32'sh8000_0000, default: 32'sh0};
        send_box(w);
        w = '{far_q: 32'sh7FFF_FFFF, near_q: 32'sh0, default: 32'shFFFF_FFFF};
        send_box(w);
        drain();

        set_ray(0);
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h1};
        for (int i = 0; i < 6; i++) begin
            w = '{lo_x: ext[i], lo_y: ext[(i+1)%6], lo_z: ext[(i+2)%6],
                  hi_x: ext[(i+3)%6], hi_y: ext[(i+4)%6], hi_z: ext[(i+5)%6],
                  near_q: ext[(i+2)%6], far_q: ext[i]};
            send_box(w);
        end
        // Unit box grazed at one corner (a miss), reversed box, empty incoming interval, early miss on x.
        w = '{lo_x: 32'sh0001_0000, lo_y: 32'shFFFF_0000, lo_z: 32'shFFFF_0000,
              hi_x: 32'sh0002_0000, hi_y: 32'sh0001_0000, hi_z: 32'sh0001_0000,
              near_q: 32'sh0, far_q: 32'sh7FFF_FFFF};
        send_box(w);
        w.lo_x = 32'sh0002_0000; w.hi_x = 32'sh0001_0000;
        send_box(w);
        w.near_q = 32'sh0005_0000; w.far_q = 32'sh0005_0000;
        send_box(w);
        w = '{lo_x: 32'shFFFE_0000, hi_x: 32'shFFFF_0000, default: 32'sh0};
        w.far_q = 32'sh7FFF_FFFF;
        send_box(w);
        drain();

        for (int mode = 1; mode < 5; mode++) begin
            set_ray(mode);
            for (int i = 0; i < 6; i++) send_box(rand_box());
            drain();
        end

        for (int phase = 0; phase < 7; phase++) begin
            set_ray(phase == 0 ? 0 : 5 + phase % 2);
            for (int i = 0; i < 240; i++) begin
                if (phase == 2 && i == 50) long_stall_req = 1'b1;
                send_box(rand_box());
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
